@@ design/accumulator_cpu_execute_step_defines.svh @@
// assertion macros for the accumulator cpu execute step
`ifndef ACCUMULATOR_CPU_EXECUTE_STEP_DEFINES_SVH
`define ACCUMULATOR_CPU_EXECUTE_STEP_DEFINES_SVH
// implication checked on every rising edge outside reset
`define ACS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication checked on every rising edge outside reset
`define ACS_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

@@ design/acs_pkg.sv @@
// ----------------------------------------------------------------------------
// acs_pkg
// shared constants, opcodes and types of the accumulator cpu execute step
// ----------------------------------------------------------------------------
package acs_pkg;
    localparam int RAM_DEPTH = 8192;
    localparam int RAM_AW = $clog2(RAM_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam logic [15:0] STACK_BASE = 16'h0100;
    localparam logic [7:0] SP_RESET = 8'hFF;
    localparam logic [7:0] SIGN_BIT = 8'h80;
    localparam logic [15:0] PC_MINUS_ONE = 16'hFFFF;

    localparam logic [5:0] OP_NOP = 6'd0;
    localparam logic [5:0] OP_LDA = 6'd1;
    localparam logic [5:0] OP_LDX = 6'd2;
    localparam logic [5:0] OP_LDY = 6'd3;
    localparam logic [5:0] OP_STA = 6'd4;
    localparam logic [5:0] OP_STX = 6'd5;
    localparam logic [5:0] OP_STY = 6'd6;
    localparam logic [5:0] OP_TAX = 6'd7;
    localparam logic [5:0] OP_TAY = 6'd8;
    localparam logic [5:0] OP_TXA = 6'd9;
    localparam logic [5:0] OP_TYA = 6'd10;
    localparam logic [5:0] OP_PHA = 6'd11;
    localparam logic [5:0] OP_PLA = 6'd12;
    localparam logic [5:0] OP_CLC = 6'd13;
    localparam logic [5:0] OP_SEC = 6'd14;
    localparam logic [5:0] OP_DEC = 6'd15;
    localparam logic [5:0] OP_DEX = 6'd16;
    localparam logic [5:0] OP_DEY = 6'd17;
    localparam logic [5:0] OP_INC = 6'd18;
    localparam logic [5:0] OP_INX = 6'd19;
    localparam logic [5:0] OP_INY = 6'd20;
    localparam logic [5:0] OP_ADC = 6'd21;
    localparam logic [5:0] OP_SBC = 6'd22;
    localparam logic [5:0] OP_ROL = 6'd23;
    localparam logic [5:0] OP_ROR = 6'd24;
    localparam logic [5:0] OP_CMP = 6'd25;
    localparam logic [5:0] OP_CPX = 6'd26;
    localparam logic [5:0] OP_CPY = 6'd27;
    localparam logic [5:0] OP_BEQ = 6'd28;
    localparam logic [5:0] OP_BNE = 6'd29;
    localparam logic [5:0] OP_BMI = 6'd30;
    localparam logic [5:0] OP_BPL = 6'd31;
    localparam logic [5:0] OP_JMP = 6'd32;
    localparam logic [5:0] OP_JSR = 6'd33;
    localparam logic [5:0] OP_RTS = 6'd34;
    localparam logic [5:0] OP_END = 6'd35;

    localparam logic [2:0] AM_IMPLIED = 3'd0;
    localparam logic [2:0] AM_IMM = 3'd1;
    localparam logic [2:0] AM_ABS = 3'd2;
    localparam logic [2:0] AM_ABSX = 3'd3;
    localparam logic [2:0] AM_ABSY = 3'd4;

    // index source for the data address
    typedef enum logic [1:0] {
        IDX_NONE = 2'd0,
        IDX_X    = 2'd1,
        IDX_Y    = 2'd2
    } t_idx;

    // classified instruction passed from front to back
    typedef struct packed {
        logic [5:0]  op;
        logic        use_imm;
        logic        use_ram;
        t_idx        idx;
        logic [15:0] operand;
    } t_instr;

    // back-end state machine
    typedef enum logic [3:0] {
        ST_EXEC  = 4'b0001,
        ST_RDWT  = 4'b0010,
        ST_STEP2 = 4'b0100,
        ST_SEND  = 4'b1000
    } t_state;
endpackage

@@ design/acs_ram.sv @@
// ----------------------------------------------------------------------------
// acs_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module acs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ design/acs_front.sv @@
// ----------------------------------------------------------------------------
// acs_front
// accepts instructions, classifies the address mode, queues them
// ----------------------------------------------------------------------------
module acs_front
    import acs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [5:0] i_operation,
    input  logic [2:0] i_address_mode,
    input  logic [15:0] i_operand,
    output logic       o_q_valid,
    input  logic       i_q_pop,
    output t_instr     o_q_instr
);
    localparam int QW = $clog2(QUEUE_DEPTH);

    t_instr r_q [QUEUE_DEPTH];
    logic [QW-1:0] r_wp, r_rp;
    logic [QW:0]   r_cnt;
    t_instr n_instr;
    logic push;

    always_comb begin
        n_instr.op      = i_operation;
        n_instr.operand = i_operand;
        n_instr.use_imm = (i_address_mode == AM_IMM);
        n_instr.use_ram = (i_address_mode == AM_ABS) || (i_address_mode == AM_ABSX)
                          || (i_address_mode == AM_ABSY);
        case (i_address_mode)
            AM_ABSX: n_instr.idx = IDX_X;
            AM_ABSY: n_instr.idx = IDX_Y;
            default: n_instr.idx = IDX_NONE;
        endcase
    end

    assign o_ready   = (r_cnt != (QW+1)'(QUEUE_DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_instr = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QW+1)'(push) - (QW+1)'(i_q_pop);
        end
        if (push) begin
            r_q[r_wp] <= n_instr;
        end
    end
endmodule

@@ design/acs_back.sv @@
// ----------------------------------------------------------------------------
// acs_back
// executes queued instructions against the registers and data ram
// ----------------------------------------------------------------------------
module acs_back
    import acs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    input  t_instr      i_q_instr,
    output logic        o_busy,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_next_pc,
    output logic [7:0]  o_acc_out,
    output logic [7:0]  o_xreg_out,
    output logic [7:0]  o_yreg_out,
    output logic [7:0]  o_stack_ptr_out,
    output logic        o_carry_out,
    output logic        o_zero_out,
    output logic        o_negative_out,
    output logic        o_halted_out
);
    t_state r_st;
    logic r_clr;
    logic [RAM_AW-1:0] r_clr_addr;
    logic [15:0] r_pc;
    logic [7:0] r_a, r_x, r_y, r_sp;
    logic r_c, r_z, r_n, r_h;
    logic [7:0] r_lo;
    logic r_ovalid;

    logic we;
    logic [RAM_AW-1:0] addr;
    logic [7:0] wdata, rdata;

    acs_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    t_instr ins;
    logic [15:0] ea16;
    logic [RAM_AW-1:0] ea, sp_a, sp1_a, sp2_a, spm1_a;
    logic need_rd, ram_rd;
    logic [7:0] data, dm1, dp1;
    logic [8:0] sum;
    logic out_free;
    logic [15:0] tgt;

    assign ins      = i_q_instr;
    assign out_free = !r_ovalid || i_ready;
    assign o_busy   = r_clr;

    function automatic logic [RAM_AW-1:0] stk(input logic [7:0] sp);
        logic [16:0] s;
        s = {1'b0, STACK_BASE} + {9'd0, sp};
        return s[RAM_AW-1:0];
    endfunction

    always_comb begin
        case (ins.idx)
            IDX_X:   ea16 = ins.operand + {8'd0, r_x};
            IDX_Y:   ea16 = ins.operand + {8'd0, r_y};
            default: ea16 = ins.operand;
        endcase
        ea     = ea16[RAM_AW-1:0];
        sp_a   = stk(r_sp);
        sp1_a  = stk(r_sp + 8'd1);
        sp2_a  = stk(r_sp + 8'd2);
        spm1_a = stk(r_sp - 8'd1);
        // instructions that read the data byte from ram
        case (ins.op)
            OP_LDA, OP_LDX, OP_LDY, OP_DEC, OP_INC, OP_ADC, OP_SBC, OP_CMP, OP_CPX,
            OP_CPY, OP_BEQ, OP_BNE, OP_BMI, OP_BPL, OP_JMP, OP_JSR:
                ram_rd = ins.use_ram;
            default: ram_rd = 1'b0;
        endcase
        need_rd = ram_rd || (ins.op == OP_PLA) || (ins.op == OP_RTS);
        if (ram_rd) begin
            data = rdata;
        end else if (ins.use_imm) begin
            data = ins.operand[7:0];
        end else begin
            data = 8'd0;
        end
        dm1 = data - 8'd1;
        dp1 = data + 8'd1;
        tgt = {8'd0, data} + PC_MINUS_ONE;
    end

    // ram port control
    always_comb begin
        we    = 1'b0;
        addr  = ea;
        wdata = 8'd0;
        o_q_pop = 1'b0;
        if (r_clr) begin
            we    = 1'b1;
            addr  = r_clr_addr;
        end else begin
            case (r_st)
                ST_EXEC: begin
                    if (i_q_valid && !r_h) begin
                        case (ins.op)
                            OP_PLA, OP_RTS: addr = sp1_a;
                            OP_PHA: addr = sp_a;
                            OP_JSR: addr = ram_rd ? ea : sp_a;
                            default: addr = ea;
                        endcase
                        if (!need_rd && out_free) begin
                            o_q_pop = 1'b1;
                            case (ins.op)
                                OP_STA: begin we = ins.use_ram; wdata = r_a; end
                                OP_STX: begin we = ins.use_ram; wdata = r_x; end
                                OP_STY: begin we = ins.use_ram; wdata = r_y; end
                                OP_PHA: begin we = 1'b1; wdata = r_a; end
                                OP_DEC: we = 1'b0;
                                OP_JSR: begin
                                    o_q_pop = 1'b0;
                                    we = 1'b1;
                                    wdata = r_pc[15:8];
                                end
                                default: we = 1'b0;
                            endcase
                        end
                    end else if (i_q_valid && out_free) begin
                        o_q_pop = 1'b1;
                    end
                end
                ST_RDWT: begin
                    case (ins.op)
                        OP_PLA: addr = sp1_a;
                        OP_RTS: addr = sp2_a;
                        OP_JSR: addr = sp_a;
                        default: addr = ea;
                    endcase
                    // stack steps of jsr and rts move on without an output slot
                    case (ins.op)
                        OP_PLA: begin
                            we = out_free; o_q_pop = out_free;
                        end
                        OP_DEC: begin
                            we = ins.use_ram && out_free; wdata = dm1; o_q_pop = out_free;
                        end
                        OP_INC: begin
                            we = ins.use_ram && out_free; wdata = dp1; o_q_pop = out_free;
                        end
                        OP_JSR: begin
                            we = 1'b1; wdata = r_pc[15:8];
                        end
                        OP_RTS: we = 1'b0;
                        default: o_q_pop = out_free;
                    endcase
                end
                ST_STEP2: begin
                    case (ins.op)
                        OP_JSR: begin
                            addr = spm1_a; we = 1'b1; wdata = r_pc[7:0];
                        end
                        default: addr = sp2_a;
                    endcase
                    o_q_pop = out_free;
                end
                default: addr = ea;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_EXEC;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_pc <= '0; r_a <= '0; r_x <= '0; r_y <= '0; r_sp <= SP_RESET;
            r_c <= 1'b0; r_z <= 1'b0; r_n <= 1'b0; r_h <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == RAM_AW'(RAM_DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end else begin
                case (r_st)
                    ST_EXEC: begin
                        if (i_q_valid && r_h) begin
                            if (out_free) r_ovalid <= 1'b1;
                        end else if (i_q_valid && (need_rd || ins.op == OP_JSR)) begin
                            r_st <= ST_RDWT;
                        end else if (i_q_valid && out_free) begin
                            r_ovalid <= 1'b1;
                            r_pc <= r_pc + 16'd1;
                            case (ins.op)
                                OP_LDA: r_a <= data;
                                OP_LDX: r_x <= data;
                                OP_LDY: r_y <= data;
                                OP_TAX: r_x <= r_a;
                                OP_TAY: r_y <= r_a;
                                OP_TXA: r_a <= r_x;
                                OP_TYA: r_a <= r_y;
                                OP_PHA: r_sp <= r_sp - 8'd1;
                                OP_CLC: r_c <= 1'b0;
                                OP_SEC: r_c <= 1'b1;
                                OP_DEC: begin r_z <= (dm1 == 0); r_n <= dm1[7]; end
                                OP_INC: begin r_z <= (dp1 == 0); r_n <= dp1[7]; end
                                OP_DEX: begin
                                    r_x <= r_x - 8'd1;
                                    r_z <= (r_x == 8'd1); r_n <= (r_x - 8'd1) >= SIGN_BIT;
                                end
                                OP_DEY: begin
                                    r_y <= r_y - 8'd1;
                                    r_z <= (r_y == 8'd1); r_n <= (r_y - 8'd1) >= SIGN_BIT;
                                end
                                OP_INX: begin
                                    r_x <= r_x + 8'd1;
                                    r_z <= (r_x == 8'hFF); r_n <= (r_x + 8'd1) >= SIGN_BIT;
                                end
                                OP_INY: begin
                                    r_y <= r_y + 8'd1;
                                    r_z <= (r_y == 8'hFF); r_n <= (r_y + 8'd1) >= SIGN_BIT;
                                end
                                OP_ADC, OP_SBC: begin
                                    r_a <= sum[7:0]; r_c <= sum[8];
                                    r_z <= (sum[7:0] == 0); r_n <= sum[7];
                                end
                                OP_ROL: begin
                                    r_a <= {r_a[6:0], r_c}; r_c <= r_a[7];
                                    r_z <= ({r_a[6:0], r_c} == 0); r_n <= r_a[6];
                                end
                                OP_ROR: begin
                                    r_a <= {r_c, r_a[7:1]}; r_c <= r_a[0];
                                    r_z <= ({r_c, r_a[7:1]} == 0); r_n <= r_c;
                                end
                                OP_CMP: begin
                                    r_z <= (r_a == data); r_n <= sum[7]; r_c <= sum[8];
                                end
                                OP_CPX: begin
                                    r_z <= (r_x == data); r_n <= sum[7]; r_c <= sum[8];
                                end
                                OP_CPY: begin
                                    r_z <= (r_y == data); r_n <= sum[7]; r_c <= sum[8];
                                end
                                OP_BEQ: if (r_z) r_pc <= tgt;
                                OP_BNE: if (!r_z) r_pc <= tgt;
                                OP_BMI: if (r_n) r_pc <= tgt;
                                OP_BPL: if (!r_n) r_pc <= tgt;
                                OP_JMP: r_pc <= tgt;
                                OP_END: begin r_h <= 1'b1; r_pc <= r_pc; end
                                default: r_pc <= r_pc + 16'd1;
                            endcase
                        end
                    end
                    ST_RDWT: begin
                        case (ins.op)
                            OP_JSR: begin
                                r_lo <= data;
                                r_st <= ST_STEP2;
                            end
                            OP_RTS: begin
                                r_lo <= rdata;
                                r_st <= ST_STEP2;
                            end
                            default: begin
                                if (out_free) begin
                                    r_st <= ST_EXEC;
                                    r_ovalid <= 1'b1;
                                    r_pc <= r_pc + 16'd1;
                                    case (ins.op)
                                        OP_PLA: begin r_a <= rdata; r_sp <= r_sp + 8'd1; end
                                        OP_LDA: r_a <= data;
                                        OP_LDX: r_x <= data;
                                        OP_LDY: r_y <= data;
                                        OP_DEC: begin
                                            r_z <= (dm1 == 0); r_n <= dm1[7];
                                        end
                                        OP_INC: begin
                                            r_z <= (dp1 == 0); r_n <= dp1[7];
                                        end
                                        OP_ADC, OP_SBC: begin
                                            r_a <= sum[7:0]; r_c <= sum[8];
                                            r_z <= (sum[7:0] == 0); r_n <= sum[7];
                                        end
                                        OP_CMP: begin
                                            r_z <= (r_a == data); r_n <= sum[7];
                                            r_c <= sum[8];
                                        end
                                        OP_CPX: begin
                                            r_z <= (r_x == data); r_n <= sum[7];
                                            r_c <= sum[8];
                                        end
                                        OP_CPY: begin
                                            r_z <= (r_y == data); r_n <= sum[7];
                                            r_c <= sum[8];
                                        end
                                        OP_BEQ: if (r_z) r_pc <= tgt;
                                        OP_BNE: if (!r_z) r_pc <= tgt;
                                        OP_BMI: if (r_n) r_pc <= tgt;
                                        OP_BPL: if (!r_n) r_pc <= tgt;
                                        OP_JMP: r_pc <= tgt;
                                        default: r_pc <= r_pc + 16'd1;
                                    endcase
                                end
                            end
                        endcase
                    end
                    ST_STEP2: begin
                        if (out_free) begin
                            r_st <= ST_EXEC;
                            r_ovalid <= 1'b1;
                            if (ins.op == OP_JSR) begin
                                r_sp <= r_sp - 8'd2;
                                r_pc <= {8'd0, r_lo} + PC_MINUS_ONE;
                            end else begin
                                r_sp <= r_sp + 8'd2;
                                r_pc <= {rdata, r_lo} + 16'd1;
                            end
                        end
                    end
                    default: r_st <= ST_EXEC;
                endcase
            end
        end
    end

    // adder shared by adc, sbc and compares
    always_comb begin
        case (ins.op)
            OP_ADC:  sum = {1'b0, r_a} + {1'b0, data} + {8'd0, r_c};
            OP_SBC:  sum = {1'b0, r_a} + {1'b0, ~data} + {8'd0, r_c};
            OP_CPX:  sum = {1'b0, r_x} + {1'b0, ~data} + 9'd1;
            OP_CPY:  sum = {1'b0, r_y} + {1'b0, ~data} + 9'd1;
            default: sum = {1'b0, r_a} + {1'b0, ~data} + 9'd1;
        endcase
    end

    assign o_valid         = r_ovalid;
    assign o_next_pc       = r_pc;
    assign o_acc_out       = r_a;
    assign o_xreg_out      = r_x;
    assign o_yreg_out      = r_y;
    assign o_stack_ptr_out = r_sp;
    assign o_carry_out     = r_c;
    assign o_zero_out      = r_z;
    assign o_negative_out  = r_n;
    assign o_halted_out    = r_h;
endmodule

@@ design/accumulator_cpu_execute_step.sv @@
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_step
// one decoded instruction of a small 6502-like accumulator machine per beat
// ----------------------------------------------------------------------------
// After reset the block clears the data ram, one byte a cycle, and takes no beat
// meanwhile. Then it accepts decoded instructions into a two-entry queue and
// reports the full register state after each one. Register-only instructions
// and stores finish in the execute state; anything that reads the single-port
// data ram (loads, alu ops from memory, inc/dec, pla) also passes the read-wait
// state, and jsr and rts the second step too, bound by the one ram port.
// ----------------------------------------------------------------------------
`include "accumulator_cpu_execute_step_defines.svh"
module accumulator_cpu_execute_step
    import acs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [5:0]  i_operation,
    input  logic [2:0]  i_address_mode,
    input  logic [15:0] i_operand,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_next_pc,
    output logic [7:0]  o_acc_out,
    output logic [7:0]  o_xreg_out,
    output logic [7:0]  o_yreg_out,
    output logic [7:0]  o_stack_ptr_out,
    output logic        o_carry_out,
    output logic        o_zero_out,
    output logic        o_negative_out,
    output logic        o_halted_out
);
    // queue handshake between front and back
    logic   q_valid, q_pop, busy, f_ready;
    t_instr q_instr;

    acs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid && !busy), .o_ready(f_ready),
        .i_operation(i_operation), .i_address_mode(i_address_mode),
        .i_operand(i_operand),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_instr(q_instr)
    );

    // no beat taken during the ram clearing pass
    assign o_ready = f_ready && !busy;

    acs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_instr(q_instr),
        .o_busy(busy),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_next_pc(o_next_pc), .o_acc_out(o_acc_out), .o_xreg_out(o_xreg_out),
        .o_yreg_out(o_yreg_out), .o_stack_ptr_out(o_stack_ptr_out),
        .o_carry_out(o_carry_out), .o_zero_out(o_zero_out),
        .o_negative_out(o_negative_out), .o_halted_out(o_halted_out)
    );

    // a pop never happens from an empty queue
    `ACS_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, q_pop, q_valid)
    // a pop always produces a result beat
    `ACS_ASSERT_NXT(a_pop_result, i_clk, i_rst_n, q_pop, o_valid)
    // halted state never clears outside reset
    `ACS_ASSERT_NXT(a_halt_sticky, i_clk, i_rst_n, o_halted_out, o_halted_out)
endmodule
